// ----- hw/rtl/kfas_pkg.sv -----
// shared types, constants and the control store of the keyframe animation sequencer
`timescale 1ns / 1ps
`default_nettype none

package kfas_pkg;

  // default ring queue depth
  localparam int unsigned QueueDepthDef = 8;

  // field widths
  localparam int unsigned ActW    = 2;
  localparam int unsigned IdW     = 8;
  localparam int unsigned FrameW  = 10;
  localparam int unsigned PeriodW = 16;
  localparam int unsigned TimeW   = 17;
  localparam int unsigned BlendW  = 17;

  // unity weight in unsigned q1.16
  localparam logic [BlendW-1:0] BlendOne = BlendW'(65536);

  // divider: one quotient bit from the set-up step, then one bit per step
  localparam int unsigned DivCntW  = 5;
  localparam logic [DivCntW-1:0] DivSteps = DivCntW'(16);

  // action codes of an input item
  typedef enum logic [ActW-1:0] {
    ACT_APPEND = 2'd0,
    ACT_CHANGE = 2'd1,
    ACT_TICK   = 2'd2
  } act_e;

  // one queued clip
  typedef struct packed {
    logic [IdW-1:0]     id;
    logic [FrameW-1:0]  first;
    logic [FrameW-1:0]  last;
    logic [PeriodW-1:0] period;
  } clip_t;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_APPEND,
    OP_CHANGE,
    OP_TICK_ADD,
    OP_FRAME_STEP,
    OP_RD_HEAD,
    OP_LOAD_CLIP,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_BLEND,
    OP_OUT
  } uop_e;

  // jump conditions
  typedef enum logic [3:0] {
    C_NONE,
    C_ALWAYS,
    C_NO_ACCEPT,
    C_APPEND,
    C_CHANGE,
    C_TICK_BUSY,
    C_NOT_OVER,
    C_NO_SWITCH,
    C_DIV_MORE,
    C_OUT_BUSY
  } cond_e;

  // program addresses
  typedef enum logic [4:0] {
    S_IDLE      = 5'd0,
    S_DISP_APP  = 5'd1,
    S_DISP_CHG  = 5'd2,
    S_DISP_TICK = 5'd3,
    S_SKIP      = 5'd4,
    S_APP       = 5'd5,
    S_CHG       = 5'd6,
    S_TICK      = 5'd7,
    S_LOOP      = 5'd8,
    S_STEP      = 5'd9,
    S_NEWRD     = 5'd10,
    S_NEWCLIP   = 5'd11,
    S_DIV       = 5'd12,
    S_DIVIT     = 5'd13,
    S_BLEND     = 5'd14,
    S_FETCH     = 5'd15,
    S_OUT       = 5'd16,
    S_RET       = 5'd17
  } step_e;

  // one control word
  typedef struct packed {
    logic  take;
    uop_e  op;
    cond_e cond;
    step_e target;
  } ctrl_t;

  // datapath flags seen by the sequencer
  typedef struct packed {
    logic is_append;
    logic is_change;
    logic tick_busy;
    logic not_over;
    logic no_switch;
    logic div_more;
  } stat_t;

  // result item as presented to the output register
  typedef struct packed {
    logic [FrameW-1:0] current_frame;
    logic [FrameW-1:0] previous_frame;
    logic [BlendW-1:0] blend_back;
    logic [IdW-1:0]    playing_clip_id;
    logic              active;
  } res_t;

  // control store
  function automatic ctrl_t ucode(input step_e s);
    ctrl_t w;
    w = '{take: 1'b0, op: OP_NONE, cond: C_NONE, target: S_IDLE};
    case (s)
      S_IDLE:      w = '{take: 1'b1, op: OP_NONE,       cond: C_NO_ACCEPT, target: S_IDLE};
      S_DISP_APP:  w = '{take: 1'b0, op: OP_NONE,       cond: C_APPEND,    target: S_APP};
      S_DISP_CHG:  w = '{take: 1'b0, op: OP_NONE,       cond: C_CHANGE,    target: S_CHG};
      S_DISP_TICK: w = '{take: 1'b0, op: OP_NONE,       cond: C_TICK_BUSY, target: S_TICK};
      S_SKIP:      w = '{take: 1'b0, op: OP_NONE,       cond: C_ALWAYS,    target: S_FETCH};
      S_APP:       w = '{take: 1'b0, op: OP_APPEND,     cond: C_ALWAYS,    target: S_FETCH};
      S_CHG:       w = '{take: 1'b0, op: OP_CHANGE,     cond: C_ALWAYS,    target: S_FETCH};
      S_TICK:      w = '{take: 1'b0, op: OP_TICK_ADD,   cond: C_NONE,      target: S_IDLE};
      S_LOOP:      w = '{take: 1'b0, op: OP_NONE,       cond: C_NOT_OVER,  target: S_DIV};
      S_STEP:      w = '{take: 1'b0, op: OP_FRAME_STEP, cond: C_NO_SWITCH, target: S_LOOP};
      S_NEWRD:     w = '{take: 1'b0, op: OP_RD_HEAD,    cond: C_NONE,      target: S_IDLE};
      S_NEWCLIP:   w = '{take: 1'b0, op: OP_LOAD_CLIP,  cond: C_NONE,      target: S_IDLE};
      S_DIV:       w = '{take: 1'b0, op: OP_DIV_INIT,   cond: C_NONE,      target: S_IDLE};
      S_DIVIT:     w = '{take: 1'b0, op: OP_DIV_STEP,   cond: C_DIV_MORE,  target: S_DIVIT};
      S_BLEND:     w = '{take: 1'b0, op: OP_BLEND,      cond: C_NONE,      target: S_IDLE};
      S_FETCH:     w = '{take: 1'b0, op: OP_RD_HEAD,    cond: C_NONE,      target: S_IDLE};
      S_OUT:       w = '{take: 1'b0, op: OP_OUT,        cond: C_OUT_BUSY,  target: S_OUT};
      S_RET:       w = '{take: 1'b0, op: OP_NONE,       cond: C_ALWAYS,    target: S_IDLE};
      default:     w = '{take: 1'b0, op: OP_NONE,       cond: C_ALWAYS,    target: S_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/kfas_queue.sv -----
// clip ring queue storage: one write port, one registered read port
`timescale 1ns / 1ps
`default_nettype none

module kfas_queue
  import kfas_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef,
  localparam int unsigned IdxW = $clog2(QUEUE_DEPTH)
) (
  input  wire logic            clk_i,
  input  wire logic            we_i,
  input  wire logic [IdxW-1:0] waddr_i,
  input  wire clip_t           wdata_i,
  input  wire logic            re_i,
  input  wire logic [IdxW-1:0] raddr_i,
  output clip_t                rdata_o
);

  clip_t mem_q [QUEUE_DEPTH];
  clip_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- hw/rtl/kfas_seq.sv -----
// microcode sequencer: step counter, control store lookup and conditional jumps
`timescale 1ns / 1ps
`default_nettype none

module kfas_seq
  import kfas_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire stat_t stat_i,
  input  wire logic  in_valid_i,
  input  wire logic  out_busy_i,
  output ctrl_t      ctrl_o
);

  step_e upc_q, upc_d;
  ctrl_t cw;
  logic  jump;

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= S_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

  // control word and branch decision
  always_comb begin
    cw = ucode(upc_q);
    case (cw.cond)
      C_NONE:      jump = 1'b0;
      C_ALWAYS:    jump = 1'b1;
      C_NO_ACCEPT: jump = !in_valid_i;
      C_APPEND:    jump = stat_i.is_append;
      C_CHANGE:    jump = stat_i.is_change;
      C_TICK_BUSY: jump = stat_i.tick_busy;
      C_NOT_OVER:  jump = stat_i.not_over;
      C_NO_SWITCH: jump = stat_i.no_switch;
      C_DIV_MORE:  jump = stat_i.div_more;
      C_OUT_BUSY:  jump = out_busy_i;
      default:     jump = 1'b0;
    endcase
    upc_d = jump ? cw.target : step_e'(upc_q + 5'd1);
  end

  assign ctrl_o = cw;

endmodule

`default_nettype wire

// ----- hw/rtl/kfas_datapath.sv -----
// sequencer datapath: clip state, queue pointers, frame stepping and blend divider
`timescale 1ns / 1ps
`default_nettype none

module kfas_datapath
  import kfas_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ctrl_t              ctrl_i,
  input  wire logic               in_fire_i,
  input  wire logic [ActW-1:0]    action_i,
  input  wire logic [IdW-1:0]     clip_id_i,
  input  wire logic [FrameW-1:0]  clip_first_frame_i,
  input  wire logic [FrameW-1:0]  clip_last_frame_i,
  input  wire logic [PeriodW-1:0] clip_period_ms_i,
  input  wire logic [PeriodW-1:0] elapsed_ms_i,
  output stat_t                   stat_o,
  output res_t                    res_o
);

  localparam int unsigned IdxW = $clog2(QUEUE_DEPTH);

  function automatic logic [IdxW-1:0] ring_next(input logic [IdxW-1:0] x);
    return (x == IdxW'(QUEUE_DEPTH - 1)) ? '0 : x + 1'b1;
  endfunction

  // latched input item
  logic [ActW-1:0]    act_q;
  clip_t              clip_q;
  logic [PeriodW-1:0] elapsed_q;

  // architectural state
  logic [IdxW-1:0]    head_q, head_d;
  logic [IdxW-1:0]    tail_q, tail_d;
  logic [FrameW-1:0]  frame_now_q, frame_now_d;
  logic [FrameW-1:0]  frame_before_q, frame_before_d;
  logic [PeriodW-1:0] period_q, period_d;
  logic [TimeW-1:0]   tacc_q, tacc_d;
  logic               sw_q, sw_d;
  logic [BlendW-1:0]  blend_q, blend_d;

  // divider
  logic [TimeW-1:0]   rem_q, rem_d;
  logic [BlendW-1:0]  quot_q, quot_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;

  // queue port
  logic               q_we, q_re;
  logic [IdxW-1:0]    q_waddr;
  clip_t              rd;

  logic               empty, switch_now;
  logic [IdxW-1:0]    head_nx, head_nx2, tail_nx;
  logic [TimeW-1:0]   period_ext, rem_sh, init_diff, step_diff;
  logic               init_ge, step_ge;

  kfas_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (q_waddr),
    .wdata_i (clip_q),
    .re_i    (q_re),
    .raddr_i (head_q),
    .rdata_o (rd)
  );

  assign empty      = (head_q == tail_q);
  assign head_nx    = ring_next(head_q);
  assign head_nx2   = ring_next(head_nx);
  assign tail_nx    = ring_next(tail_q);
  assign switch_now = sw_q || (frame_now_q >= rd.last);
  assign period_ext = {1'b0, period_q};
  assign init_ge    = (tacc_q >= period_ext);
  assign init_diff  = tacc_q - period_ext;
  assign rem_sh     = {rem_q[TimeW-2:0], 1'b0};
  assign step_ge    = (rem_sh >= period_ext);
  assign step_diff  = rem_sh - period_ext;

  // input item capture, zero period stored as one
  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      act_q        <= action_i;
      clip_q.id    <= clip_id_i;
      clip_q.first <= clip_first_frame_i;
      clip_q.last  <= clip_last_frame_i;
      clip_q.period <= (clip_period_ms_i == '0) ? PeriodW'(1) : clip_period_ms_i;
      elapsed_q    <= elapsed_ms_i;
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q         <= '0;
      tail_q         <= '0;
      frame_now_q    <= '0;
      frame_before_q <= '0;
      period_q       <= PeriodW'(1);
      tacc_q         <= '0;
      sw_q           <= 1'b0;
      blend_q        <= '0;
      cnt_q          <= '0;
    end else begin
      head_q         <= head_d;
      tail_q         <= tail_d;
      frame_now_q    <= frame_now_d;
      frame_before_q <= frame_before_d;
      period_q       <= period_d;
      tacc_q         <= tacc_d;
      sw_q           <= sw_d;
      blend_q        <= blend_d;
      cnt_q          <= cnt_d;
    end
  end

  // divider working registers
  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
  end

  // operation decode
  always_comb begin
    head_d         = head_q;
    tail_d         = tail_q;
    frame_now_d    = frame_now_q;
    frame_before_d = frame_before_q;
    period_d       = period_q;
    tacc_d         = tacc_q;
    sw_d           = sw_q;
    blend_d        = blend_q;
    rem_d          = rem_q;
    quot_d         = quot_q;
    cnt_d          = cnt_q;
    q_we           = 1'b0;
    q_re           = 1'b0;
    q_waddr        = tail_q;
    case (ctrl_i.op)
      OP_APPEND: begin
        if (empty) begin
          frame_before_d = clip_q.first;
          frame_now_d    = (clip_q.last > clip_q.first) ? clip_q.first + 1'b1 : clip_q.first;
          period_d       = clip_q.period;
          tacc_d         = '0;
          blend_d        = '0;
        end
        q_we    = 1'b1;
        q_waddr = tail_q;
        tail_d  = tail_nx;
      end
      OP_CHANGE: begin
        if (empty) begin
          frame_before_d = clip_q.first;
          frame_now_d    = (clip_q.last > clip_q.first) ? clip_q.first + 1'b1 : clip_q.first;
          period_d       = clip_q.period;
          tacc_d         = '0;
          blend_d        = BlendOne;
          q_waddr        = tail_q;
          tail_d         = tail_nx;
        end else begin
          q_waddr = head_nx;
          tail_d  = head_nx2;
          if (clip_q.period < period_q) begin
            period_d = clip_q.period;
          end
        end
        q_we = 1'b1;
        sw_d = 1'b1;
      end
      OP_TICK_ADD: begin
        tacc_d = tacc_q + TimeW'(elapsed_q);
        q_re   = 1'b1;
      end
      OP_FRAME_STEP: begin
        tacc_d         = tacc_q - period_ext;
        frame_before_d = frame_now_q;
        if (switch_now) begin
          if (head_nx != tail_q) begin
            head_d = head_nx;
          end
          tacc_d = '0;
          sw_d   = 1'b0;
        end else begin
          period_d    = rd.period;
          frame_now_d = frame_now_q + 1'b1;
        end
      end
      OP_RD_HEAD: begin
        q_re = 1'b1;
      end
      OP_LOAD_CLIP: begin
        period_d    = rd.period;
        frame_now_d = rd.first;
      end
      OP_DIV_INIT: begin
        rem_d  = init_ge ? init_diff : tacc_q;
        quot_d = {{(BlendW-1){1'b0}}, init_ge};
        cnt_d  = DivSteps;
      end
      OP_DIV_STEP: begin
        rem_d  = step_ge ? step_diff : rem_sh;
        quot_d = {quot_q[BlendW-2:0], step_ge};
        cnt_d  = cnt_q - 1'b1;
      end
      OP_BLEND: begin
        blend_d = BlendOne - quot_q;
      end
      default: begin
      end
    endcase
  end

  // flags for the sequencer
  always_comb begin
    stat_o.is_append = (act_q == ACT_APPEND);
    stat_o.is_change = (act_q == ACT_CHANGE);
    stat_o.tick_busy = (act_q == ACT_TICK) && !empty;
    stat_o.not_over  = (tacc_q <= period_ext);
    stat_o.no_switch = !switch_now;
    stat_o.div_more  = (cnt_q != DivCntW'(1));
  end

  // result fields, head clip read back in the fetch step
  always_comb begin
    res_o.current_frame   = frame_now_q;
    res_o.previous_frame  = frame_before_q;
    res_o.blend_back      = blend_q;
    res_o.active          = !empty;
    res_o.playing_clip_id = empty ? '0 : rd.id;
  end

  // the divider starts only once the frame loop has used up the time
  a_div_init_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.op == OP_DIV_INIT) |-> (tacc_q <= period_ext))
    else $error("accumulated time above period at divider start");

  // partial remainder stays below the divisor
  a_div_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.op == OP_DIV_STEP) |-> (rem_q < period_ext))
    else $error("divider remainder out of range");

  // quotient never exceeds unity weight
  a_quot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.op == OP_BLEND) |-> (quot_q <= BlendOne))
    else $error("blend quotient above one");

  // a running period of zero would stall the frame loop
  a_period_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    period_q != '0)
    else $error("period register is zero");

endmodule

`default_nettype wire

// ----- hw/rtl/keyframe_animation_sequencer_top.sv -----
// Keyframe animation sequencer, top level with output register
//
// Input channel (in_valid_i / in_ready_o) takes one command per transfer:
// append a clip, change to a clip, or a time tick carrying elapsed_ms_i.
// Output channel (out_valid_o / out_ready_i) returns exactly one result per
// command: current and previous frame, back blend weight in q1.16, id of the
// clip at the queue head and an active flag.
// One command is worked at a time by a microcoded sequencer. A tick runs the
// frame loop, one subtract per step, and then the 17-step shift-subtract
// divider for the blend. in_ready_o is high only in the idle step, which
// follows the return step after the result is loaded.
// The result sits in an output register; a new command is taken while an
// earlier result waits, and the sequencer holds in its output step if that
// register is still full when the next result is ready.
// Reset empties the queue, zeroes frames, time and blend, sets the running
// period to one and drops any pending output. Queue contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module keyframe_animation_sequencer_top
  import kfas_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire logic [ActW-1:0]    action_i,
  input  wire logic [IdW-1:0]     clip_id_i,
  input  wire logic [FrameW-1:0]  clip_first_frame_i,
  input  wire logic [FrameW-1:0]  clip_last_frame_i,
  input  wire logic [PeriodW-1:0] clip_period_ms_i,
  input  wire logic [PeriodW-1:0] elapsed_ms_i,
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      logic [FrameW-1:0]  current_frame_o,
  output      logic [FrameW-1:0]  previous_frame_o,
  output      logic [BlendW-1:0]  blend_back_o,
  output      logic [IdW-1:0]     playing_clip_id_o,
  output      logic               active_o
);

  ctrl_t ctrl;
  stat_t stat;
  res_t  res;
  res_t  out_q;
  logic  out_valid_q, out_valid_d;
  logic  out_busy, out_load, in_fire;

  assign in_ready_o = ctrl.take;
  assign in_fire    = in_valid_i && ctrl.take;
  assign out_busy   = out_valid_q && !out_ready_i;
  assign out_load   = (ctrl.op == OP_OUT) && !out_busy;

  kfas_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .stat_i     (stat),
    .in_valid_i (in_valid_i),
    .out_busy_i (out_busy),
    .ctrl_o     (ctrl)
  );

  kfas_datapath #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .ctrl_i             (ctrl),
    .in_fire_i          (in_fire),
    .action_i           (action_i),
    .clip_id_i          (clip_id_i),
    .clip_first_frame_i (clip_first_frame_i),
    .clip_last_frame_i  (clip_last_frame_i),
    .clip_period_ms_i   (clip_period_ms_i),
    .elapsed_ms_i       (elapsed_ms_i),
    .stat_o             (stat),
    .res_o              (res)
  );

  // output valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign current_frame_o   = out_q.current_frame;
  assign previous_frame_o  = out_q.previous_frame;
  assign blend_back_o      = out_q.blend_back;
  assign playing_clip_id_o = out_q.playing_clip_id;
  assign active_o          = out_q.active;

endmodule

`default_nettype wire

// ----- sim/kfas_pose_checker.sv -----
`timescale 1ns / 1ps
// pose checker: predicts every result of the keyframe animation sequencer and compares it
module kfas_pose_checker
  import kfas_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               in_ready_i,
  input  wire logic [ActW-1:0]    action_i,
  input  wire logic [IdW-1:0]     clip_id_i,
  input  wire logic [FrameW-1:0]  clip_first_frame_i,
  input  wire logic [FrameW-1:0]  clip_last_frame_i,
  input  wire logic [PeriodW-1:0] clip_period_ms_i,
  input  wire logic [PeriodW-1:0] elapsed_ms_i,
  input  wire logic               out_valid_i,
  input  wire logic               out_ready_i,
  input  wire logic [FrameW-1:0]  current_frame_i,
  input  wire logic [FrameW-1:0]  previous_frame_i,
  input  wire logic [BlendW-1:0]  blend_back_i,
  input  wire logic [IdW-1:0]     playing_clip_id_i,
  input  wire logic               active_i,
  output int                      mismatch_count_o,
  output int                      results_due_o
);

  // only the first few mismatches are printed, all are counted
  localparam int unsigned ReportCap = 40;

  // predicted sequencer state
  clip_t             clip_ring [QUEUE_DEPTH];
  int unsigned       head_slot;
  int unsigned       tail_slot;
  logic [FrameW-1:0]  frame_cur;
  logic [FrameW-1:0]  frame_prev;
  logic [PeriodW-1:0] period_run;
  logic [TimeW-1:0]   time_acc;
  logic               switch_due;
  logic [BlendW-1:0]  blend_cur;

  // poses still owed by the block, oldest first
  res_t pose_queue [$];

  int mismatch_total = 0;
  int due_total = 0;
  int unsigned poses_seen = 0;

  assign mismatch_count_o = mismatch_total;
  assign results_due_o    = due_total;

  function automatic int unsigned ring_next(input int unsigned slot);
    return (slot + 1 < QUEUE_DEPTH) ? slot + 1 : 0;
  endfunction

  task automatic report_mismatch(input string field, input longint unsigned got,
                                 input longint unsigned want);
    mismatch_total++;
    if (mismatch_total <= ReportCap)
      $display("%0t: pose %0d, %s differs: got %0d, expected %0d",
               $time, poses_seen, field, got, want);
  endtask

  // load a clip onto an empty queue
  task automatic start_clip(input clip_t c, input logic [BlendW-1:0] blend);
    frame_prev = c.first;
    frame_cur  = (c.last > c.first) ? c.first + 1'b1 : c.first;
    blend_cur  = blend;
    period_run = c.period;
    time_acc   = '0;
  endtask

  // consume elapsed time frame by frame, then derive the back weight
  task automatic advance_time(input logic [PeriodW-1:0] elapsed);
    logic [32:0] quotient;
    clip_t       head_clip;
    if (head_slot == tail_slot) return;
    time_acc = time_acc + elapsed;
    while (time_acc > period_run) begin
      head_clip = clip_ring[head_slot];
      time_acc  = time_acc - period_run;
      if (switch_due || frame_cur >= head_clip.last) begin
        // move on unless the next slot is the tail, then replay the last clip
        if (ring_next(head_slot) != tail_slot) head_slot = ring_next(head_slot);
        head_clip  = clip_ring[head_slot];
        time_acc   = '0;
        period_run = head_clip.period;
        frame_prev = frame_cur;
        frame_cur  = head_clip.first;
        switch_due = 1'b0;
      end else begin
        period_run = head_clip.period;
        frame_prev = frame_cur;
        frame_cur  = frame_cur + 1'b1;
      end
    end
    quotient  = {time_acc, 16'h0000} / {17'h00000, period_run};
    blend_cur = (quotient >= 33'(BlendOne)) ? '0 : BlendOne - BlendW'(quotient);
  endtask

  // work out the pose that one accepted command leads to
  task automatic predict_pose(input logic [ActW-1:0] act, input clip_t item,
                              input logic [PeriodW-1:0] elapsed);
    logic was_empty;
    res_t pose;
    was_empty = (head_slot == tail_slot);
    if (item.period == '0) item.period = PeriodW'(1);
    case (act)
      ACT_APPEND: begin
        if (was_empty) start_clip(item, '0);
        clip_ring[tail_slot] = item;
        tail_slot = ring_next(tail_slot);
      end
      ACT_CHANGE: begin
        // a change drops everything queued after the running clip
        if (was_empty) begin
          start_clip(item, BlendOne);
        end else begin
          tail_slot = ring_next(head_slot);
          if (item.period < period_run) period_run = item.period;
        end
        clip_ring[tail_slot] = item;
        tail_slot  = ring_next(tail_slot);
        switch_due = 1'b1;
      end
      ACT_TICK: advance_time(elapsed);
      default: ;
    endcase
    pose.current_frame   = frame_cur;
    pose.previous_frame  = frame_prev;
    pose.blend_back      = blend_cur;
    pose.active          = (head_slot != tail_slot);
    pose.playing_clip_id = pose.active ? clip_ring[head_slot].id : '0;
    pose_queue.push_back(pose);
  endtask

  // compare one result transfer with the oldest predicted pose
  task automatic check_pose(input res_t seen);
    res_t want;
    poses_seen++;
    if (pose_queue.size() == 0) begin
      report_mismatch("result with nothing pending, frame", seen.current_frame, 0);
      return;
    end
    want = pose_queue.pop_front();
    if (seen.current_frame !== want.current_frame)
      report_mismatch("current_frame", seen.current_frame, want.current_frame);
    if (seen.previous_frame !== want.previous_frame)
      report_mismatch("previous_frame", seen.previous_frame, want.previous_frame);
    if (seen.blend_back !== want.blend_back)
      report_mismatch("blend_back", seen.blend_back, want.blend_back);
    if (seen.playing_clip_id !== want.playing_clip_id)
      report_mismatch("playing_clip_id", seen.playing_clip_id, want.playing_clip_id);
    if (seen.active !== want.active)
      report_mismatch("active", seen.active, want.active);
  endtask

  // watch both channels; results are checked before the new command is predicted
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) clip_ring[i] = '0;
      head_slot  = 0;
      tail_slot  = 0;
      frame_cur  = '0;
      frame_prev = '0;
      period_run = PeriodW'(1);
      time_acc   = '0;
      switch_due = 1'b0;
      blend_cur  = '0;
      pose_queue.delete();
      due_total <= 0;
    end else begin
      if (out_valid_i && out_ready_i)
        check_pose('{current_frame: current_frame_i, previous_frame: previous_frame_i,
                     blend_back: blend_back_i, playing_clip_id: playing_clip_id_i,
                     active: active_i});
      if (in_valid_i && in_ready_i)
        predict_pose(action_i,
                     '{id: clip_id_i, first: clip_first_frame_i, last: clip_last_frame_i,
                       period: clip_period_ms_i},
                     elapsed_ms_i);
      due_total <= pose_queue.size();
    end
  end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// testbench top: clock, reset, command stimulus and verdict for the keyframe animation sequencer
module tb;
  import kfas_pkg::*;

  localparam int unsigned RandomItems = 700;
  localparam int unsigned CycleLimit  = 12_000_000;
  localparam int unsigned DrainCycles = 64;
  // the one action code the block ignores
  localparam logic [ActW-1:0] ActIgnored = 2'd3;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               in_valid   = 1'b0;
  logic               in_ready;
  logic [ActW-1:0]    action     = ActIgnored;
  logic [IdW-1:0]     clip_id    = '0;
  logic [FrameW-1:0]  clip_first = '0;
  logic [FrameW-1:0]  clip_last  = '0;
  logic [PeriodW-1:0] clip_period = '0;
  logic [PeriodW-1:0] elapsed    = '0;
  logic               out_valid;
  logic               out_ready  = 1'b0;
  logic [FrameW-1:0]  current_frame;
  logic [FrameW-1:0]  previous_frame;
  logic [BlendW-1:0]  blend_back;
  logic [IdW-1:0]     playing_clip_id;
  logic               active;

  int unsigned send_idle_pct = 12;
  int unsigned recv_idle_pct = 76;
  int unsigned cycle_count   = 0;
  int          mismatch_count;
  int          results_due;

  keyframe_animation_sequencer_top #(
    .QUEUE_DEPTH(QueueDepthDef)
  ) dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .action_i           (action),
    .clip_id_i          (clip_id),
    .clip_first_frame_i (clip_first),
    .clip_last_frame_i  (clip_last),
    .clip_period_ms_i   (clip_period),
    .elapsed_ms_i       (elapsed),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .current_frame_o    (current_frame),
    .previous_frame_o   (previous_frame),
    .blend_back_o       (blend_back),
    .playing_clip_id_o  (playing_clip_id),
    .active_o           (active)
  );

  kfas_pose_checker #(
    .QUEUE_DEPTH(QueueDepthDef)
  ) pose_check (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_ready_i         (in_ready),
    .action_i           (action),
    .clip_id_i          (clip_id),
    .clip_first_frame_i (clip_first),
    .clip_last_frame_i  (clip_last),
    .clip_period_ms_i   (clip_period),
    .elapsed_ms_i       (elapsed),
    .out_valid_i        (out_valid),
    .out_ready_i        (out_ready),
    .current_frame_i    (current_frame),
    .previous_frame_i   (previous_frame),
    .blend_back_i       (blend_back),
    .playing_clip_id_i  (playing_clip_id),
    .active_i           (active),
    .mismatch_count_o   (mismatch_count),
    .results_due_o      (results_due)
  );

  // 8 ns clock
  initial begin
    forever #4 clk = ~clk;
  end

  // watchdog on a hung handshake
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // one command transfer, with an optional idle gap in front
  task automatic send_command(input logic [ActW-1:0] act, input logic [IdW-1:0] id,
                              input logic [FrameW-1:0] first, input logic [FrameW-1:0] last,
                              input logic [PeriodW-1:0] period,
                              input logic [PeriodW-1:0] elapsed_ms);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid    <= 1'b1;
    action      <= act;
    clip_id     <= id;
    clip_first  <= first;
    clip_last   <= last;
    clip_period <= period;
    elapsed     <= elapsed_ms;
    do @(posedge clk); while (!in_ready);
  endtask

  initial begin : stimulus
    int unsigned        pick;
    logic [ActW-1:0]    act;
    logic [IdW-1:0]     id;
    logic [FrameW-1:0]  first;
    logic [FrameW-1:0]  last;
    logic [PeriodW-1:0] period;
    logic [PeriodW-1:0] elapsed_ms;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // eight appends from empty fill the ring until the tail meets the head again
    send_command(ACT_APPEND, 8'hff, 10'd1023, 10'd1023, 16'd0, 16'hffff);
    send_command(ACT_APPEND, 8'h00, 10'd0, 10'd1023, 16'hffff, 16'd0);
    send_command(ACT_APPEND, 8'h55, 10'h2aa, 10'h155, 16'h5555, 16'haaaa);
    send_command(ACT_APPEND, 8'haa, 10'h155, 10'h2aa, 16'haaaa, 16'h5555);
    send_command(ACT_APPEND, 8'h01, 10'd7, 10'd7, 16'd1, 16'd0);
    send_command(ACT_APPEND, 8'h80, 10'd512, 10'd520, 16'd3, 16'd0);
    send_command(ACT_APPEND, 8'h7f, 10'd1, 10'd0, 16'd2, 16'd0);
    send_command(ACT_APPEND, 8'h10, 10'd100, 10'd110, 16'd10, 16'd0);
    // ring now reads as empty: tick and the ignored code change nothing
    send_command(ACT_TICK, 8'h00, 10'd0, 10'd0, 16'd1, 16'hffff);
    send_command(ActIgnored, 8'hff, 10'd1023, 10'd1023, 16'hffff, 16'hffff);
    // change on an empty ring starts with full back weight
    send_command(ACT_CHANGE, 8'h81, 10'd5, 10'd9, 16'd3, 16'd0);
    send_command(ACT_TICK, 8'h00, 10'd0, 10'd0, 16'd0, 16'd1);
    send_command(ACT_TICK, 8'h00, 10'd0, 10'd0, 16'd0, 16'd2);
    send_command(ACT_TICK, 8'h00, 10'd0, 10'd0, 16'd0, 16'd3);
    send_command(ACT_TICK, 8'h00, 10'd0, 10'd0, 16'd0, 16'd7);
    // zero period stored as one, then a change that shortens nothing
    send_command(ACT_APPEND, 8'hff, 10'd1023, 10'd1023, 16'd0, 16'd0);
    send_command(ACT_CHANGE, 8'h00, 10'd0, 10'd1023, 16'hffff, 16'd0);
    send_command(ACT_TICK, 8'h00, 10'd0, 10'd0, 16'd0, 16'hffff);
    send_command(ACT_APPEND, 8'h3c, 10'd0, 10'd1023, 16'hffff, 16'd0);
    send_command(ACT_TICK, 8'h00, 10'd0, 10'd0, 16'd0, 16'd32768);
    send_command(ACT_TICK, 8'h00, 10'd0, 10'd0, 16'd0, 16'd0);

    // random commands: mostly appends and ticks, some changes and ignored codes
    for (int i = 0; i < RandomItems; i++) begin
      if (i == RandomItems / 3) begin
        send_idle_pct = 76;
        recv_idle_pct = 12;
      end
      if (i == 2 * RandomItems / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      pick  = $urandom_range(0, 99);
      act   = (pick < 30) ? ACT_APPEND : (pick < 40) ? ACT_CHANGE :
              (pick < 95) ? ACT_TICK : ActIgnored;
      id    = IdW'($urandom);
      first = FrameW'($urandom);
      // short clips mostly, now and then any span, backwards included
      if ($urandom_range(0, 3) != 0) last = first + FrameW'($urandom_range(0, 12));
      else last = FrameW'($urandom);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: period = PeriodW'($urandom_range(1, 40));
        5, 6, 7:       period = PeriodW'($urandom_range(41, 3000));
        8:             period = PeriodW'($urandom);
        default:       period = ($urandom_range(0, 1) != 0) ? '1 : '0;
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: elapsed_ms = PeriodW'($urandom_range(0, 60));
        6, 7, 8:          elapsed_ms = PeriodW'($urandom_range(0, 4000));
        default:          elapsed_ms = PeriodW'($urandom);
      endcase
      send_command(act, id, first, last, period, elapsed_ms);
    end
    in_valid <= 1'b0;

    // drain outstanding results, then allow for the block's own latency
    do @(posedge clk); while (results_due != 0);
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0 && results_due == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
